@@ src/assert_macros.svh @@
// Assertion macros used by the RTL file of the hash table block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge, switched off while reset is asserted.
`define CHAT_ASSERT(lbl, prop, msg) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CHAT_ASSERT_ALWAYS(lbl, prop, msg) \
lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ src/chat_pkg.sv @@
// Types and constants of the coalesced hash attribute table.
package chat_pkg;

    localparam int unsigned SLOTS_DEFAULT = 64;

    localparam int KEY_W      = 32;
    localparam int HASH_W     = 32;
    localparam int VALUE_W    = 64;
    localparam int SLOT_OUT_W = 6;
    localparam int OP_W       = 2;
    localparam int STATUS_W   = 3;

    localparam int IN_DATA_W  = 136;
    localparam int OUT_DATA_W = 72;

    // Home slot reduction for table sizes that are not a power of two.
    localparam int MOD_DIGIT_W = 4;
    localparam int MOD_STEPS   = HASH_W / MOD_DIGIT_W;
    localparam int MOD_CNT_W   = $clog2(MOD_STEPS);

    typedef enum logic [OP_W-1:0] {
        OP_SET         = 2'd0,
        OP_FIND        = 2'd1,
        OP_FIND_SHARED = 2'd2
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_STORED   = 3'd0,
        ST_FOUND    = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_LOCAL    = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_MOD,
        S_RD_HOME,
        S_SRCH,
        S_FREE_RD,
        S_FREE_CHK,
        S_HOME2_RD,
        S_HOME2,
        S_LINK_H,
        S_PREV_RD,
        S_PREV,
        S_PUT_H,
        S_RESP
    } state_t;

endpackage

@@ src/coalesced_hash_attribute_table_unit.sv @@
// Coalesced hash table of key tags and values with Brent style insertion.
//
// The block keeps SLOTS entries (key tag, home slot, next link, 64-bit value,
// local mark, used bit) in one single-port synchronous memory and serves one
// request transaction at a time: set, find or find_shared. Each request gives
// exactly one result transaction on the master side, and an output register
// lets a new request enter while that result still waits. After reset the
// block clears the used bits of all slots before it takes its first request.
// A request reads its home slot and then walks the chain one entry at a
// time; when SLOTS is not a power of two the home slot is first reduced from
// the hash four bits a cycle. A set that misses scans downward for a free
// slot, then links the new key in after a home slot that holds its own chain,
// or moves a foreign entry out of the home slot, relinks that entry's chain
// and puts the new key in the home slot. Every step is bounded by the single
// memory port, which does one read or one write per cycle. A result then
// moves into the output register once that register is free.
`include "assert_macros.svh"

module coalesced_hash_attribute_table_unit
    import chat_pkg::*;
#(
    parameter int unsigned SLOTS = SLOTS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // Fields from bit 0: key_tag[31:0], key_hash[63:32], write_value[127:64],
    // mark_local[128], zero fill up to bit 135.
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // Fields from bit 0: operation[1:0].
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // Fields from bit 0: read_value[63:0], slot_index[69:64], zero fill.
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // Fields from bit 0: status[2:0].
    output logic [STATUS_W-1:0]   m_axis_tuser
);

    localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int LINK_W = IDX_W + 1;
    localparam bit POW2   = ((SLOTS & (SLOTS - 1)) == 0);
    localparam logic [LINK_W-1:0] LINK_END = LINK_W'(SLOTS);
    localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(SLOTS - 1);

    typedef struct packed {
        logic              used;
        logic              is_local;
        logic [KEY_W-1:0]  key;
        logic [IDX_W-1:0]  home;
        logic [LINK_W-1:0] link;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Table memory: one port, registered read data.
    entry_t mem [SLOTS];
    entry_t dout_reg;
    logic   mem_we;
    logic   mem_re;
    logic [IDX_W-1:0] mem_addr;
    entry_t mem_wdata;

    state_t state_reg, state_next;

    logic [OP_W-1:0]     op_reg, op_next;
    logic [KEY_W-1:0]    tag_reg, tag_next;
    logic [HASH_W-1:0]   hash_reg, hash_next;
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic                lcl_reg, lcl_next;
    logic [IDX_W-1:0]    h_reg, h_next;
    logic [MOD_CNT_W-1:0] mod_cnt_reg, mod_cnt_next;
    logic [IDX_W-1:0]    cur_reg, cur_next;
    logic [IDX_W-1:0]    step_reg, step_next;
    logic [LINK_W-1:0]   p_reg, p_next;
    logic [LINK_W-1:0]   fp_reg, fp_next;
    logic [IDX_W-1:0]    f_reg, f_next;
    logic [IDX_W-1:0]    prev_reg, prev_next;
    logic [IDX_W-1:0]    clr_reg, clr_next;
    status_t             res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    logic [IDX_W-1:0]    res_where_reg, res_where_next;
    logic                m_valid_reg, m_valid_next;
    status_t             m_status_reg, m_status_next;
    logic [VALUE_W-1:0]  m_value_reg, m_value_next;
    logic [SLOT_OUT_W-1:0] m_slot_reg, m_slot_next;

    // Decisions on the entry just read.
    logic is_set, is_find, is_shared, op_valid;
    logic hit, chain_end, home_empty, link_is_h;
    logic [LINK_W-1:0] p_dec;
    logic [IDX_W-1:0]  mod_h;
    logic              load_out;
    entry_t new_entry;
    entry_t blank_entry;

    assign is_set     = (op_reg == OP_SET);
    assign is_find    = (op_reg == OP_FIND);
    assign is_shared  = (op_reg == OP_FIND_SHARED);
    assign op_valid   = is_set || is_find || is_shared;
    assign hit        = dout_reg.used && (dout_reg.key == tag_reg);
    assign chain_end  = (step_reg == LAST_IDX) || (dout_reg.link >= LINK_END);
    assign home_empty = (step_reg == '0) && !dout_reg.used;
    assign link_is_h  = (dout_reg.link == {1'b0, h_reg});
    assign p_dec      = p_reg - LINK_W'(1);
    assign load_out   = !m_valid_reg || m_axis_tready;

    always_comb
    begin
        new_entry          = '0;
        new_entry.used     = 1'b1;
        new_entry.is_local = lcl_reg;
        new_entry.key      = tag_reg;
        new_entry.home     = h_reg;
        new_entry.link     = LINK_END;
        new_entry.value    = val_reg;
        blank_entry        = '0;
        blank_entry.link   = LINK_END;
    end

    // Four restoring remainder steps per cycle, most significant bits first.
    always_comb
    begin
        logic [LINK_W-1:0] rem;
        rem = {1'b0, h_reg};
        for (int i = 0; i < MOD_DIGIT_W; i++)
        begin
            rem = {rem[IDX_W-1:0], hash_reg[HASH_W-1-i]};
            if (rem >= LINK_END)
            begin
                rem = rem - LINK_END;
            end
        end
        mod_h = rem[IDX_W-1:0];
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
                if (clr_reg == LAST_IDX) state_next = S_IDLE;
            S_IDLE:
                if (s_axis_tvalid) state_next = POW2 ? S_RD_HOME : S_MOD;
            S_MOD:
                if (mod_cnt_reg == MOD_CNT_W'(MOD_STEPS - 1)) state_next = S_RD_HOME;
            S_RD_HOME:
                state_next = S_SRCH;
            S_SRCH:
                if (!op_valid || home_empty || hit) state_next = S_RESP;
                else if (chain_end) state_next = is_set ? S_FREE_RD : S_RESP;
            S_FREE_RD:
                state_next = (p_reg == '0) ? S_RESP : S_FREE_CHK;
            S_FREE_CHK:
                state_next = dout_reg.used ? S_FREE_RD : S_HOME2_RD;
            S_HOME2_RD:
                state_next = S_HOME2;
            S_HOME2:
                state_next = (dout_reg.home == h_reg) ? S_LINK_H : S_PREV_RD;
            S_LINK_H:
                state_next = S_RESP;
            S_PREV_RD:
                state_next = S_PREV;
            S_PREV:
                if (link_is_h || chain_end) state_next = S_PUT_H;
            S_PUT_H:
                state_next = S_RESP;
            S_RESP:
                if (load_out) state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath, memory control and result registers.
    always_comb
    begin
        op_next         = op_reg;
        tag_next        = tag_reg;
        hash_next       = hash_reg;
        val_next        = val_reg;
        lcl_next        = lcl_reg;
        h_next          = h_reg;
        mod_cnt_next    = mod_cnt_reg;
        cur_next        = cur_reg;
        step_next       = step_reg;
        p_next          = p_reg;
        fp_next         = fp_reg;
        f_next          = f_reg;
        prev_next       = prev_reg;
        clr_next        = clr_reg;
        res_status_next = res_status_reg;
        res_value_next  = res_value_reg;
        res_where_next  = res_where_reg;
        m_valid_next    = m_valid_reg && !m_axis_tready;
        m_status_next   = m_status_reg;
        m_value_next    = m_value_reg;
        m_slot_next     = m_slot_reg;
        mem_we          = 1'b0;
        mem_re          = 1'b0;
        mem_addr        = '0;
        mem_wdata       = dout_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_addr  = clr_reg;
                mem_wdata = blank_entry;
                clr_next  = clr_reg + IDX_W'(1);
            end
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next         = s_axis_tuser;
                    tag_next        = s_axis_tdata[31:0];
                    hash_next       = s_axis_tdata[63:32];
                    val_next        = s_axis_tdata[127:64];
                    lcl_next        = s_axis_tdata[128];
                    h_next          = POW2 ? s_axis_tdata[32 +: IDX_W] : '0;
                    mod_cnt_next    = '0;
                    res_status_next = ST_NOTFOUND;
                    res_value_next  = '0;
                    res_where_next  = '0;
                end
            end
            S_MOD:
            begin
                hash_next    = hash_reg << MOD_DIGIT_W;
                h_next       = mod_h;
                mod_cnt_next = mod_cnt_reg + MOD_CNT_W'(1);
            end
            S_RD_HOME:
            begin
                mem_re    = 1'b1;
                mem_addr  = h_reg;
                cur_next  = h_reg;
                step_next = '0;
            end
            S_SRCH:
            begin
                if (!op_valid)
                begin
                    res_status_next = ST_NOTFOUND;
                end
                else if (home_empty)
                begin
                    if (is_set)
                    begin
                        mem_we          = 1'b1;
                        mem_addr        = h_reg;
                        mem_wdata       = new_entry;
                        res_status_next = ST_STORED;
                        res_where_next  = h_reg;
                    end
                end
                else if (hit)
                begin
                    if (is_set)
                    begin
                        res_where_next = cur_reg;
                        if (dout_reg.is_local)
                        begin
                            res_status_next = ST_LOCAL;
                        end
                        else
                        begin
                            mem_we          = 1'b1;
                            mem_addr        = cur_reg;
                            mem_wdata.value = val_reg;
                            res_status_next = ST_STORED;
                        end
                    end
                    else if (!(is_shared && dout_reg.is_local))
                    begin
                        res_status_next = ST_FOUND;
                        res_value_next  = dout_reg.value;
                        res_where_next  = cur_reg;
                    end
                end
                else if (chain_end)
                begin
                    p_next = (fp_reg > LINK_END) ? LINK_END : fp_reg;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_addr  = dout_reg.link[IDX_W-1:0];
                    cur_next  = dout_reg.link[IDX_W-1:0];
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_FREE_RD:
            begin
                if (p_reg == '0)
                begin
                    res_status_next = ST_FULL;
                end
                else
                begin
                    mem_re   = 1'b1;
                    mem_addr = p_dec[IDX_W-1:0];
                    p_next   = p_dec;
                end
            end
            S_FREE_CHK:
            begin
                if (!dout_reg.used)
                begin
                    fp_next = p_reg;
                    f_next  = p_reg[IDX_W-1:0];
                end
            end
            S_HOME2_RD:
            begin
                mem_re   = 1'b1;
                mem_addr = h_reg;
            end
            S_HOME2:
            begin
                mem_we   = 1'b1;
                mem_addr = f_reg;
                if (dout_reg.home == h_reg)
                begin
                    // The home slot holds its own chain: link the new key in after it.
                    mem_wdata      = new_entry;
                    mem_wdata.link = dout_reg.link;
                    res_where_next = f_reg;
                end
                else
                begin
                    // A foreign entry sits here: move it out to the free slot.
                    mem_wdata      = dout_reg;
                    prev_next      = dout_reg.home;
                    step_next      = '0;
                    res_where_next = h_reg;
                end
            end
            S_LINK_H:
            begin
                mem_we          = 1'b1;
                mem_addr        = h_reg;
                mem_wdata.link  = {1'b0, f_reg};
                res_status_next = ST_STORED;
            end
            S_PREV_RD:
            begin
                mem_re   = 1'b1;
                mem_addr = prev_reg;
            end
            S_PREV:
            begin
                if (link_is_h)
                begin
                    mem_we         = 1'b1;
                    mem_addr       = prev_reg;
                    mem_wdata.link = {1'b0, f_reg};
                end
                else if (!chain_end)
                begin
                    mem_re    = 1'b1;
                    mem_addr  = dout_reg.link[IDX_W-1:0];
                    prev_next = dout_reg.link[IDX_W-1:0];
                    step_next = step_reg + IDX_W'(1);
                end
            end
            S_PUT_H:
            begin
                mem_we          = 1'b1;
                mem_addr        = h_reg;
                mem_wdata       = new_entry;
                res_status_next = ST_STORED;
            end
            S_RESP:
            begin
                if (load_out)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = res_status_reg;
                    m_value_next  = res_value_reg;
                    m_slot_next   = SLOT_OUT_W'(res_where_reg);
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_addr] <= mem_wdata;
        end
        if (mem_re)
        begin
            dout_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            fp_reg      <= LINK_END;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_reg     <= clr_next;
            fp_reg      <= fp_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        tag_reg        <= tag_next;
        hash_reg       <= hash_next;
        val_reg        <= val_next;
        lcl_reg        <= lcl_next;
        h_reg          <= h_next;
        mod_cnt_reg    <= mod_cnt_next;
        cur_reg        <= cur_next;
        step_reg       <= step_next;
        p_reg          <= p_next;
        f_reg          <= f_next;
        prev_reg       <= prev_next;
        res_status_reg <= res_status_next;
        res_value_reg  <= res_value_next;
        res_where_reg  <= res_where_next;
        m_status_reg   <= m_status_next;
        m_value_reg    <= m_value_next;
        m_slot_reg     <= m_slot_next;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {2'b00, m_slot_reg, m_value_reg};
    assign m_axis_tuser  = m_status_reg;

    `CHAT_ASSERT(a_fp_range, fp_reg <= LINK_END, "free pointer above slot count")
    `CHAT_ASSERT(a_fp_descends, !$stable(fp_reg) |-> fp_reg < $past(fp_reg), "free pointer rose")
    `CHAT_ASSERT(a_single_port, !(mem_we && mem_re), "memory read and write in one cycle")
    `CHAT_ASSERT(a_walk_start, (state_reg == S_SRCH) && (step_reg == '0) |-> cur_reg == h_reg, "chain walk did not start at home slot")

endmodule
